FILE: sv/o3ik_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and word types for the omni3 kinematics block.
// Used by the front end, the series cells, the back end and the top level.
package o3ik_pkg;

  localparam int TFB        = 15;
  localparam int SFB        = 4;
  localparam int SPD_W      = 14;
  localparam int HDG_W      = 17;
  localparam int PWM_W      = 10;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int WHEELS     = 3;
  localparam int TERMS      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM      = 1'd1;
  localparam logic [MASK_W-1:0]    MASK_RESET       = 3'd0;
  localparam logic [PWM_W-1:0]     MAX_PWM_RESET    = 10'd255;

  localparam int X_W    = 30;
  localparam int TERM_W = 31;
  localparam int SUM_W  = 33;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam int          ANG_DIV = 18000;
  localparam logic [17:0] PI_INT  = 18'(PI_Q30 / 64'd18000);
  localparam logic [12:0] PI_REM  = 13'(PI_Q30 % 64'd18000);
  localparam int          ANG_S   = 40;
  localparam logic [25:0] ANG_M   = 26'((64'd1 << ANG_S) / 64'd18000);
  localparam logic [TERM_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam int TRIG_W  = TFB + 2;
  localparam int UT_W    = TFB + 1;
  localparam int K_BITS  = 24;
  localparam logic [25:0] SQRT3_Q24 = 26'd29058991;
  localparam int VEL_W   = SPD_W + TRIG_W;
  localparam int ROOT_W  = VEL_W + 26;
  localparam int NUM_W   = TFB + 42;
  localparam int G_SH    = SFB + TFB + K_BITS;
  localparam int U_W     = NUM_W - G_SH;
  localparam int DIV3_S  = U_W + 2;
  localparam logic [DIV3_S-1:0] DIV3_M = DIV3_S'((64'd1 << DIV3_S) / 64'd3);

  typedef struct packed {
    logic [1:0]              quad;
    logic                    swap;
    logic signed [SPD_W-1:0] spd;
    logic signed [SPD_W-1:0] ang;
  } side_t;

  typedef struct packed {
    logic [TERM_W-1:0]       ts;
    logic [TERM_W-1:0]       tc;
    logic [X_W-1:0]          x2;
    logic signed [SUM_W-1:0] ss;
    logic signed [SUM_W-1:0] cs;
    side_t                   side;
  } chain_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic             fwd;
  } wheel_t;

endpackage

FILE: sv/omni3_inverse_kinematics.sv
`timescale 1ns / 1ps
// Three-wheel omni drive inverse kinematics, top level.
// Depends on o3ik_pkg, o3ik_front, o3ik_cell and o3ik_back.
//
// Usage:
//   in_* carries one command word: linear speed, heading in centidegrees and
//   angular speed. out_* carries one result word per command: for each of
//   the three wheels a PWM magnitude and a forward bit.
//   cfg_* writes reverse_mask (index 0) and max_pwm (index 1); write only
//   while no command is in flight.
// Throughput: one command per cycle while out_tready is high, fully pipelined.
// From accept to out_tvalid: 6 front stages (heading fold, radian
//   conversion with a reciprocal divide, squaring), 6 series cells of 3
//   stages each (two multiplies and a constant divide per term), and 6
//   back stages (rounding, velocity multiply, sqrt3 multiply, mix, scale,
//   divide by three and clamp).
// Reset: rst_n clears all valid flags; reverse_mask goes to 0, max_pwm to 255.
// Stall: when out_tready is low each stage holds its word and bubbles close;
//   in_tready drops only once every stage is occupied.
module omni3_inverse_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] linear_speed, [30:14] heading_centideg, [44:31] angular_speed
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] wheel0_pwm, [10] wheel0_forward, [20:11] wheel1_pwm,
  // [21] wheel1_forward, [31:22] wheel2_pwm, [32] wheel2_forward
  output logic [39:0] out_tdata,
  input  logic                                cfg_we,
  input  logic [o3ik_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [o3ik_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N = o3ik_pkg::TERMS;

  logic [o3ik_pkg::MASK_W-1:0] mask_r;
  logic [o3ik_pkg::PWM_W-1:0]  max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= o3ik_pkg::MASK_RESET;
      max_r  <= o3ik_pkg::MAX_PWM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        o3ik_pkg::REG_REVERSE_MASK: mask_r <= cfg_data[o3ik_pkg::MASK_W-1:0];
        o3ik_pkg::REG_MAX_PWM:      max_r  <= cfg_data[o3ik_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [o3ik_pkg::SPD_W-1:0] spd, ang;
  logic signed [o3ik_pkg::HDG_W-1:0] hdg;

  assign spd = in_tdata[13:0];
  assign hdg = in_tdata[30:14];
  assign ang = in_tdata[44:31];

  logic             cv [N+1];
  logic             cr [N+1];
  o3ik_pkg::chain_t cd [N+1];

  o3ik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_spd    (spd),
    .in_hdg    (hdg),
    .in_ang    (ang),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    o3ik_cell #(.K(k + 1)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .in_data   (cd[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .out_data  (cd[k+1])
    );
  end

  o3ik_pkg::wheel_t [o3ik_pkg::WHEELS-1:0] wheel;

  o3ik_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv[N]),
    .in_ready  (cr[N]),
    .in_data   (cd[N]),
    .mask      (mask_r),
    .max_pwm   (max_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_wheel (wheel)
  );

  assign out_tdata = {7'd0,
                      wheel[2].fwd, wheel[2].pwm,
                      wheel[1].fwd, wheel[1].pwm,
                      wheel[0].fwd, wheel[0].pwm};

endmodule

FILE: sv/o3ik_front.sv
`timescale 1ns / 1ps
// Heading reduction to one octant, angle to Q30 radians and angle squared.
// Depends on o3ik_pkg; feeds the first series cell.
module o3ik_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [o3ik_pkg::SPD_W-1:0] in_spd,
  input  logic signed [o3ik_pkg::HDG_W-1:0] in_hdg,
  input  logic signed [o3ik_pkg::SPD_W-1:0] in_ang,
  output logic                             out_valid,
  input  logic                             out_ready,
  output o3ik_pkg::chain_t                 out_data
);

  logic [5:0] v_r;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = !v_r[5] || out_ready;
    for (int j = 4; j >= 0; j--) rdy[j] = !v_r[j] || rdy[j+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int j = 1; j < 6; j++) if (rdy[j]) v_r[j] <= v_r[j-1];
    end
  end

  // stage 1: wrap to 0..35999
  logic signed [18:0] hx;
  logic [17:0]        u;
  logic [15:0]        r_nxt, r_r;
  o3ik_pkg::side_t    s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;

  always_comb begin
    hx = 19'(in_hdg) + 19'sd72000;
    u  = hx[17:0];
    priority if (u >= 18'd108000) r_nxt = 16'(u - 18'd108000);
    else if (u >= 18'd72000)      r_nxt = 16'(u - 18'd72000);
    else if (u >= 18'd36000)      r_nxt = 16'(u - 18'd36000);
    else                          r_nxt = u[15:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      r_r       <= r_nxt;
      s1_r.quad <= 2'd0;
      s1_r.swap <= 1'b0;
      s1_r.spd  <= in_spd;
      s1_r.ang  <= in_ang;
    end
  end

  // stage 2: quadrant and octant fold
  logic [1:0]  q_nxt;
  logic [15:0] a16;
  logic [13:0] a;
  logic [12:0] b_nxt, b_r;
  logic        sw_nxt;

  always_comb begin
    priority if (r_r >= 16'd27000) begin
      q_nxt = 2'd3; a16 = r_r - 16'd27000;
    end else if (r_r >= 16'd18000) begin
      q_nxt = 2'd2; a16 = r_r - 16'd18000;
    end else if (r_r >= 16'd9000) begin
      q_nxt = 2'd1; a16 = r_r - 16'd9000;
    end else begin
      q_nxt = 2'd0; a16 = r_r;
    end
    a      = a16[13:0];
    sw_nxt = a > 14'd4500;
    b_nxt  = sw_nxt ? 13'(14'd9000 - a) : a[12:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && v_r[0]) begin
      b_r  <= b_nxt;
      s2_r <= '{quad: q_nxt, swap: sw_nxt, spd: s1_r.spd, ang: s1_r.ang};
    end
  end

  // stage 3: split b*pi/18000 into whole and fractional parts
  logic [30:0] base_r, base4_r;
  logic [24:0] t_r, t4_r;

  always_ff @(posedge clk) begin
    if (rdy[2] && v_r[1]) begin
      base_r <= 31'(b_r * o3ik_pkg::PI_INT);
      t_r    <= 25'(b_r * o3ik_pkg::PI_REM) + 25'd9000;
      s3_r   <= s2_r;
    end
  end

  // stage 4: reciprocal multiply
  logic [50:0] m_r;

  always_ff @(posedge clk) begin
    if (rdy[3] && v_r[2]) begin
      m_r     <= t_r * o3ik_pkg::ANG_M;
      t4_r    <= t_r;
      base4_r <= base_r;
      s4_r    <= s3_r;
    end
  end

  // stage 5: correct quotient, form x
  logic [10:0] q0;
  logic [24:0] rem;
  logic [o3ik_pkg::X_W-1:0] x_nxt, x_r, x6_r;

  always_comb begin
    q0    = m_r[50:o3ik_pkg::ANG_S];
    rem   = t4_r - 25'(q0 * 15'(o3ik_pkg::ANG_DIV));
    x_nxt = 30'(base4_r) + 30'(q0) + 30'(rem >= 25'(o3ik_pkg::ANG_DIV));
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v_r[3]) begin
      x_r  <= x_nxt;
      s5_r <= s4_r;
    end
  end

  // stage 6: square
  logic [2*o3ik_pkg::X_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    if (rdy[5] && v_r[4]) begin
      sq_r <= x_r * x_r;
      x6_r <= x_r;
      s6_r <= s5_r;
    end
  end

  always_comb begin
    out_data.ts   = {1'b0, x6_r};
    out_data.tc   = o3ik_pkg::ONE_Q30;
    out_data.x2   = sq_r[2*o3ik_pkg::X_W-1:30];
    out_data.ss   = $signed({3'b000, x6_r});
    out_data.cs   = $signed({2'b00, o3ik_pkg::ONE_Q30});
    out_data.side = s6_r;
  end

endmodule

FILE: sv/o3ik_cell.sv
`timescale 1ns / 1ps
// One Taylor term cell: next sine and cosine terms and the running sums.
// Depends on o3ik_pkg; chained between the front and back ends.
module o3ik_cell #(
  parameter int K = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  o3ik_pkg::chain_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output o3ik_pkg::chain_t out_data
);

  localparam int TW = o3ik_pkg::TERM_W;
  localparam int PW = TW + o3ik_pkg::X_W;
  localparam logic [63:0] DS = 64'((2 * K) * (2 * K + 1));
  localparam logic [63:0] DC = 64'((2 * K - 1) * (2 * K));
  localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
  localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
  localparam bit          SUB = (K % 2) == 1;

  logic a_v_r, b_v_r, c_v_r;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c     = !c_v_r || out_ready;
  assign rdy_b     = !b_v_r || rdy_c;
  assign rdy_a     = !a_v_r || rdy_b;
  assign in_ready  = rdy_a;
  assign out_valid = c_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
    end
  end

  logic [PW-1:0]     a_ps_r, a_pc_r;
  o3ik_pkg::chain_t  a_d_r, b_d_r, c_d_r;

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_ps_r <= in_data.ts * in_data.x2;
      a_pc_r <= in_data.tc * in_data.x2;
      a_d_r  <= in_data;
    end
  end

  logic [TW-1:0]   ps, pc, b_ps_r, b_pc_r;
  logic [TW+31:0]  b_ms_r, b_mc_r;

  assign ps = a_ps_r[PW-1:30];
  assign pc = a_pc_r[PW-1:30];

  always_ff @(posedge clk) begin
    if (rdy_b && a_v_r) begin
      b_ms_r <= ps * MS;
      b_mc_r <= pc * MC;
      b_ps_r <= ps;
      b_pc_r <= pc;
      b_d_r  <= a_d_r;
    end
  end

  logic [TW-1:0] qs0, qc0, rs, rc, qs_nxt, qc_nxt;
  logic signed [o3ik_pkg::SUM_W-1:0] ss_nxt, cs_nxt;

  always_comb begin
    qs0    = b_ms_r[TW+31:32];
    qc0    = b_mc_r[TW+31:32];
    rs     = b_ps_r - TW'(qs0 * TW'(DS));
    rc     = b_pc_r - TW'(qc0 * TW'(DC));
    qs_nxt = qs0 + TW'(rs >= TW'(DS));
    qc_nxt = qc0 + TW'(rc >= TW'(DC));
    if (SUB) begin
      ss_nxt = b_d_r.ss - $signed({2'b00, qs_nxt});
      cs_nxt = b_d_r.cs - $signed({2'b00, qc_nxt});
    end else begin
      ss_nxt = b_d_r.ss + $signed({2'b00, qs_nxt});
      cs_nxt = b_d_r.cs + $signed({2'b00, qc_nxt});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && b_v_r) begin
      c_d_r <= '{ts: qs_nxt, tc: qc_nxt, x2: b_d_r.x2, ss: ss_nxt, cs: cs_nxt,
                 side: b_d_r.side};
    end
  end

  assign out_data = c_d_r;

endmodule

FILE: sv/o3ik_back.sv
`timescale 1ns / 1ps
// Trig rounding and quadrant restore, velocity split, wheel mix, scaling and clamp.
// Depends on o3ik_pkg; its last stage is the output register.
module o3ik_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  o3ik_pkg::chain_t                in_data,
  input  logic [o3ik_pkg::MASK_W-1:0]     mask,
  input  logic [o3ik_pkg::PWM_W-1:0]      max_pwm,
  output logic                            out_valid,
  input  logic                            out_ready,
  output o3ik_pkg::wheel_t [o3ik_pkg::WHEELS-1:0] out_wheel
);

  localparam int TFB  = o3ik_pkg::TFB;
  localparam int TW   = o3ik_pkg::TRIG_W;
  localparam int UTW  = o3ik_pkg::UT_W;
  localparam int SW   = o3ik_pkg::SUM_W;
  localparam int NW   = o3ik_pkg::NUM_W;
  localparam int GS   = o3ik_pkg::G_SH;
  localparam int UW   = o3ik_pkg::U_W;
  localparam int DS3  = o3ik_pkg::DIV3_S;
  localparam int VW   = o3ik_pkg::VEL_W;
  localparam int RW   = o3ik_pkg::ROOT_W;
  localparam logic [NW-1:0] HALF = NW'(3) << (GS - 1);
  localparam logic [SW-1:0] RBIAS = SW'(1) << (29 - TFB);

  logic [5:0] v_r;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = !v_r[5] || out_ready;
    for (int j = 4; j >= 0; j--) rdy[j] = !v_r[j] || rdy[j+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int j = 1; j < 6; j++) if (rdy[j]) v_r[j] <= v_r[j-1];
    end
  end

  // stage 1: round to trig precision, restore quadrant
  logic [SW-1:0]  sr, cr;
  logic [UTW-1:0] sa, ca;
  logic signed [TW-1:0] ps, pc, sn_nxt, cs_nxt, sn_r, cs_r;
  logic signed [o3ik_pkg::SPD_W-1:0] spd_r, ang1_r, ang2_r, ang3_r;

  always_comb begin
    sr = in_data.ss[SW-1] ? '0 : (SW'(in_data.ss) + RBIAS);
    cr = in_data.cs[SW-1] ? '0 : (SW'(in_data.cs) + RBIAS);
    if (in_data.side.swap) begin
      sa = UTW'(cr >> (30 - TFB));
      ca = UTW'(sr >> (30 - TFB));
    end else begin
      sa = UTW'(sr >> (30 - TFB));
      ca = UTW'(cr >> (30 - TFB));
    end
    ps = $signed({1'b0, sa});
    pc = $signed({1'b0, ca});
    unique case (in_data.side.quad)
      2'd0: begin sn_nxt = ps;  cs_nxt = pc;  end
      2'd1: begin sn_nxt = pc;  cs_nxt = -ps; end
      2'd2: begin sn_nxt = -ps; cs_nxt = -pc; end
      2'd3: begin sn_nxt = -pc; cs_nxt = ps;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      sn_r   <= sn_nxt;
      cs_r   <= cs_nxt;
      spd_r  <= in_data.side.spd;
      ang1_r <= in_data.side.ang;
    end
  end

  // stage 2: vx and vy
  logic signed [VW-1:0] vx_r, vy_r;

  always_ff @(posedge clk) begin
    if (rdy[1] && v_r[0]) begin
      vx_r   <= VW'(spd_r) * VW'(sn_r);
      vy_r   <= VW'(spd_r) * VW'(cs_r);
      ang2_r <= ang1_r;
    end
  end

  // stage 3: sqrt3 term and scaled terms
  logic signed [RW-1:0] root_r;
  logic signed [NW-1:0] vxk_r, wk_r;

  always_ff @(posedge clk) begin
    if (rdy[2] && v_r[1]) begin
      root_r <= RW'(vy_r) * $signed({1'b0, o3ik_pkg::SQRT3_Q24});
      vxk_r  <= NW'(vx_r) <<< o3ik_pkg::K_BITS;
      wk_r   <= NW'(ang2_r) <<< (TFB + o3ik_pkg::K_BITS);
      ang3_r <= ang2_r;
    end
  end

  // stage 4: wheel numerators
  logic signed [NW-1:0] num_r [o3ik_pkg::WHEELS];

  always_ff @(posedge clk) begin
    if (rdy[3] && v_r[2]) begin
      num_r[0] <= wk_r - vxk_r + NW'(root_r);
      num_r[1] <= wk_r - vxk_r - NW'(root_r);
      num_r[2] <= wk_r + (vxk_r <<< 1);
    end
  end

  // stage 5: magnitude, add one and a half, drop fraction
  logic [NW-1:0] mag [o3ik_pkg::WHEELS];
  logic [NW-1:0] rnd [o3ik_pkg::WHEELS];
  logic [UW-1:0] u_r [o3ik_pkg::WHEELS];
  logic [o3ik_pkg::WHEELS-1:0] neg_r;

  always_comb begin
    for (int i = 0; i < o3ik_pkg::WHEELS; i++) begin
      mag[i] = num_r[i][NW-1] ? NW'(-num_r[i]) : NW'(num_r[i]);
      rnd[i] = mag[i] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v_r[3]) begin
      for (int i = 0; i < o3ik_pkg::WHEELS; i++) begin
        u_r[i]   <= rnd[i][NW-1:GS];
        neg_r[i] <= num_r[i][NW-1];
      end
    end
  end

  // stage 6: divide by three, clamp, direction
  logic [UW+DS3-1:0] prod [o3ik_pkg::WHEELS];
  logic [UW-1:0]     q0 [o3ik_pkg::WHEELS];
  logic [UW-1:0]     rm [o3ik_pkg::WHEELS];
  logic [UW-1:0]     q [o3ik_pkg::WHEELS];
  o3ik_pkg::wheel_t [o3ik_pkg::WHEELS-1:0] wh_nxt, wh_r;

  always_comb begin
    for (int i = 0; i < o3ik_pkg::WHEELS; i++) begin
      prod[i] = (UW+DS3)'(u_r[i]) * (UW+DS3)'(o3ik_pkg::DIV3_M);
      q0[i]   = prod[i][UW+DS3-1:DS3];
      rm[i]   = u_r[i] - UW'(q0[i] * UW'(3));
      q[i]    = q0[i] + UW'(rm[i] >= UW'(3));
      wh_nxt[i].pwm = (q[i] > UW'(max_pwm)) ? max_pwm : q[i][o3ik_pkg::PWM_W-1:0];
      wh_nxt[i].fwd = !neg_r[i] ^ mask[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5] && v_r[4]) wh_r <= wh_nxt;
  end

  assign out_wheel = wh_r;

endmodule
